/* rtl/fpns_pkg.sv */
// Shared types and constants for the fixed-pattern-noise subtract core.
// No dependencies; used by fixed_pattern_noise_subtract_core.
package fpns_pkg;

   localparam int NOISE_COUNT = 4;

   localparam logic [6:0] NOISE_CHAN [NOISE_COUNT] = '{7'd11, 7'd22, 7'd45, 7'd56};

   localparam logic [11:0] FLOOR_RESET = 12'd10;

   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_EVENT = 2'd2;

   localparam logic CSR_FPN_ENABLE  = 1'b0;
   localparam logic CSR_NOISE_FLOOR = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_ISSUE,
      ST_LD_ADD,
      ST_RD_ISSUE,
      ST_RD_CAPT,
      ST_DIV,
      ST_SUB,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] idx;
   } noise_match_type;

   function automatic noise_match_type noise_match(input logic [6:0] chan);
      noise_match_type m;
      m = '0;
      for (int i = 0; i < NOISE_COUNT; i++) begin
         if (chan == NOISE_CHAN[i]) begin
            m.hit = 1'b1;
            m.idx = 2'(i);
         end
      end
      return m;
   endfunction

   function automatic logic [2:0] seen_count(input logic [3:0] mask);
      logic [2:0] n;
      n = '0;
      for (int i = 0; i < NOISE_COUNT; i++) begin
         n = n + 3'(mask[i]);
      end
      return n;
   endfunction

endpackage

/* rtl/fpns_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module fpns_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/fixed_pattern_noise_subtract_core.sv */
// Top level of the fixed-pattern-noise subtract core.
// Uses fpns_pkg and two fpns_ram instances (sample store, noise sums).
//
// Usage:
//   req_* carries one command per transfer: tuser is the kind (load, read,
//   new event), tdata the chip, channel, bucket and sample. rsp_* returns
//   one Q4 corrected sample for each read; loads and new events return
//   nothing. csr_* writes fpn_enable (index 0) and noise_floor (index 1).
//   The core takes one command at a time and holds req_tready low while
//   it works on it. What each command does, in order:
//     load of a normal channel   writes the sample store
//     load of a noise channel    also reads the noise sum and adds the sample to it
//     read, correction off or no noise channel seen   reads store and sum, captures, subtracts
//     read with correction       as above, and divides the noise sum by the count
//                                of seen noise channels, bit-serially (DIVW = SAMPLE_BITS + 6)
//     new event                  clears the seen marks and sweeps the noise sums to zero
//   After reset the noise-sum memory (CHIPS*BUCKETS entries, 2048 at defaults)
//   is swept to zero, with req_tready low. The sample store is not cleared.
//   A finished result sits in the output register until rsp_tready; the core
//   goes on taking commands, and only a following read waits there.
module fixed_pattern_noise_subtract_core #(
   parameter int CHIPS       = 4,
   parameter int CHANNELS    = 68,
   parameter int BUCKETS     = 512,
   parameter int SAMPLE_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // chip[1:0], channel[8:2], bucket[17:9], sample_value[29:18]
   input  logic [1:0]  req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // corrected_q4
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata
);

   localparam int SW         = SAMPLE_BITS;
   localparam int SUMW       = SW + 2;
   localparam int DIVW       = SUMW + 4;
   localparam int RW         = (DIVW > 16) ? DIVW : 16;
   localparam int CNTW       = $clog2(DIVW);
   localparam int CW         = (CHIPS > 1) ? $clog2(CHIPS) : 1;
   localparam int STORE_DEPTH = CHIPS * CHANNELS * BUCKETS;
   localparam int SUMS_DEPTH = CHIPS * BUCKETS;
   localparam int STW        = $clog2(STORE_DEPTH);
   localparam int SMW        = $clog2(SUMS_DEPTH);

   fpns_pkg::state_type state_ff, state_in;

   logic            enable_ff, enable_in;
   logic [11:0]     floor_ff, floor_in;
   logic [1:0]      chip_ff, chip_in;
   logic [6:0]      chan_ff, chan_in;
   logic [8:0]      bucket_ff, bucket_in;
   logic [SW-1:0]   sample_ff, sample_in;
   logic            range_ff, range_in;
   logic [3:0]      seen_ff [CHIPS];
   logic            seen_clr, seen_set;
   logic [SMW-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [DIVW-1:0] div_q_ff, div_q_in;
   logic [1:0]      div_rem_ff, div_rem_in;
   logic [2:0]      div_den_ff, div_den_in;
   logic [CNTW-1:0] div_cnt_ff, div_cnt_in;
   logic [RW:0]     diff_ff, diff_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [15:0]     rsp_data_ff, rsp_data_in;

   logic              req_fire;
   logic              range_req;
   fpns_pkg::noise_match_type match;
   logic [STW-1:0]    store_addr;
   logic [SMW-1:0]    sums_addr;
   logic              store_we, store_re;
   logic [SW-1:0]     store_rdata;
   logic              sums_we, sums_re;
   logic [SMW-1:0]    sums_waddr;
   logic [SUMW-1:0]   sums_wdata, sums_rdata;
   logic [2:0]        seen_n;
   logic [2:0]        trial;
   logic              trial_ge;
   logic              out_load;
   logic [RW-1:0]     raw_q4, floor_q4, fin_val;

   assign req_tready = (state_ff == fpns_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign range_req = (int'(req_tdata[1:0]) < CHIPS) && (int'(req_tdata[8:2]) < CHANNELS)
                      && (int'(req_tdata[17:9]) < BUCKETS);
   assign match      = fpns_pkg::noise_match(chan_ff);
   assign store_addr = STW'((int'(chip_ff) * CHANNELS + int'(chan_ff)) * BUCKETS
                            + int'(bucket_ff));
   assign sums_addr  = SMW'(int'(chip_ff) * BUCKETS + int'(bucket_ff));
   assign seen_n     = fpns_pkg::seen_count(seen_ff[CW'(chip_ff)]);

   assign trial    = {div_rem_ff, div_q_ff[DIVW-1]};
   assign trial_ge = (trial >= div_den_ff);

   assign raw_q4   = RW'({sample_ff, 4'b0000});
   assign floor_q4 = RW'({floor_ff, 4'b0000});

   // state machine and memory control
   always_comb begin
      state_in   = state_ff;
      store_we   = 1'b0;
      store_re   = 1'b0;
      sums_we    = 1'b0;
      sums_re    = 1'b0;
      sums_waddr = sums_addr;
      sums_wdata = SUMW'(sums_rdata + SUMW'(sample_ff));
      seen_clr   = 1'b0;
      seen_set   = 1'b0;
      clr_cnt_in = clr_cnt_ff;
      out_load   = 1'b0;
      unique case (state_ff)
         fpns_pkg::ST_CLEAR: begin
            sums_we    = 1'b1;
            sums_waddr = clr_cnt_ff;
            sums_wdata = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == SMW'(SUMS_DEPTH - 1)) begin
               clr_cnt_in = '0;
               state_in   = fpns_pkg::ST_IDLE;
            end
         end
         fpns_pkg::ST_IDLE: begin
            if (req_fire) begin
               unique case (req_tuser)
                  fpns_pkg::KIND_LOAD: begin
                     if (range_req) state_in = fpns_pkg::ST_LD_ISSUE;
                  end
                  fpns_pkg::KIND_READ:  state_in = fpns_pkg::ST_RD_ISSUE;
                  fpns_pkg::KIND_EVENT: begin
                     seen_clr = 1'b1;
                     state_in = fpns_pkg::ST_CLEAR;
                  end
                  default: state_in = fpns_pkg::ST_IDLE;
               endcase
            end
         end
         fpns_pkg::ST_LD_ISSUE: begin
            store_we = 1'b1;
            if (match.hit) begin
               sums_re  = 1'b1;
               seen_set = 1'b1;
               state_in = fpns_pkg::ST_LD_ADD;
            end else begin
               state_in = fpns_pkg::ST_IDLE;
            end
         end
         fpns_pkg::ST_LD_ADD: begin
            sums_we  = 1'b1;
            state_in = fpns_pkg::ST_IDLE;
         end
         fpns_pkg::ST_RD_ISSUE: begin
            store_re = 1'b1;
            sums_re  = 1'b1;
            state_in = fpns_pkg::ST_RD_CAPT;
         end
         fpns_pkg::ST_RD_CAPT: begin
            if (enable_ff && seen_n != 3'd0) state_in = fpns_pkg::ST_DIV;
            else state_in = fpns_pkg::ST_SUB;
         end
         fpns_pkg::ST_DIV: begin
            if (div_cnt_ff == CNTW'(DIVW - 1)) state_in = fpns_pkg::ST_SUB;
         end
         fpns_pkg::ST_SUB: begin
            state_in = fpns_pkg::ST_FIN;
         end
         fpns_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = fpns_pkg::ST_IDLE;
            end
         end
         default: state_in = fpns_pkg::ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      enable_in   = enable_ff;
      floor_in    = floor_ff;
      chip_in     = chip_ff;
      chan_in     = chan_ff;
      bucket_in   = bucket_ff;
      sample_in   = sample_ff;
      range_in    = range_ff;
      div_q_in    = div_q_ff;
      div_rem_in  = div_rem_ff;
      div_den_in  = div_den_ff;
      div_cnt_in  = div_cnt_ff;
      diff_in     = diff_ff;
      rsp_data_in = rsp_data_ff;
      fin_val     = raw_q4;

      if (csr_we) begin
         unique case (csr_index)
            fpns_pkg::CSR_FPN_ENABLE:  enable_in = csr_wdata[0];
            fpns_pkg::CSR_NOISE_FLOOR: floor_in  = csr_wdata;
            default: ;
         endcase
      end

      if (req_fire) begin
         chip_in   = req_tdata[1:0];
         chan_in   = req_tdata[8:2];
         bucket_in = req_tdata[17:9];
         sample_in = SW'(req_tdata[29:18]);
         range_in  = range_req;
      end

      if (state_ff == fpns_pkg::ST_RD_CAPT) begin
         sample_in  = store_rdata;
         div_rem_in = '0;
         div_cnt_in = '0;
         div_den_in = seen_n;
         div_q_in   = '0;
         if (enable_ff && seen_n != 3'd0) begin
            div_q_in = DIVW'({sums_rdata, 4'b0000}) + DIVW'(seen_n[2:1]);
         end
      end

      if (state_ff == fpns_pkg::ST_DIV) begin
         div_rem_in = trial_ge ? 2'(trial - div_den_ff) : trial[1:0];
         div_q_in   = {div_q_ff[DIVW-2:0], trial_ge};
         div_cnt_in = div_cnt_ff + 1'b1;
      end

      if (state_ff == fpns_pkg::ST_SUB) begin
         diff_in = {1'b0, raw_q4} - {1'b0, RW'(div_q_ff)};
      end

      if (enable_ff) begin
         if (diff_ff[RW] || diff_ff[RW-1:0] < floor_q4) fin_val = floor_q4;
         else fin_val = diff_ff[RW-1:0];
      end
      if (out_load) begin
         if (!range_ff) rsp_data_in = '0;
         else if (fin_val > RW'(16'hFFFF)) rsp_data_in = 16'hFFFF;
         else rsp_data_in = fin_val[15:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpns_pkg::ST_CLEAR;
         enable_ff    <= 1'b0;
         floor_ff     <= fpns_pkg::FLOOR_RESET;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         floor_ff     <= floor_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chip_ff     <= chip_in;
      chan_ff     <= chan_in;
      bucket_ff   <= bucket_in;
      sample_ff   <= sample_in;
      range_ff    <= range_in;
      div_q_ff    <= div_q_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      div_cnt_ff  <= div_cnt_in;
      diff_ff     <= diff_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < CHIPS; c++) begin
         if (reset || seen_clr) begin
            seen_ff[c] <= '0;
         end else if (seen_set && CW'(chip_ff) == CW'(c)) begin
            seen_ff[c] <= seen_ff[c] | (4'b0001 << match.idx);
         end
      end
   end

   fpns_ram #(
      .WIDTH (SW),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_addr),
      .wr_data (sample_ff),
      .rd_en   (store_re),
      .rd_addr (store_addr),
      .rd_data (store_rdata)
   );

   fpns_ram #(
      .WIDTH (SUMW),
      .DEPTH (SUMS_DEPTH)
   ) u_sums (
      .clock   (clock),
      .wr_en   (sums_we),
      .wr_addr (sums_waddr),
      .wr_data (sums_wdata),
      .rd_en   (sums_re),
      .rd_addr (sums_addr),
      .rd_data (sums_rdata)
   );

   a_clear_writes_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == fpns_pkg::ST_CLEAR |-> sums_we && sums_wdata == '0)
      else $error("sum sweep not writing zero");

   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == fpns_pkg::ST_DIV |-> {1'b0, div_rem_ff} < div_den_ff)
      else $error("divider remainder not below divisor");

   a_div_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == fpns_pkg::ST_DIV |-> int'(div_cnt_ff) < DIVW)
      else $error("divider step count overrun");

   a_fin_loads_output: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff && state_ff == fpns_pkg::ST_IDLE)
      else $error("result not presented after finish");

   a_div_nonzero_den: assert property (@(posedge clock) disable iff (reset)
      state_ff == fpns_pkg::ST_DIV |-> div_den_ff != 3'd0 && div_den_ff <= 3'd4)
      else $error("divider started with bad divisor");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for fixed_pattern_noise_subtract_core.
// Depends on rtl/fpns_pkg.sv and the core; predicts each read result from a shadow
// copy of the sample store, noise sums and seen marks, and checks the rsp stream.
module tb_top;

   localparam int CHIPS        = 4;
   localparam int CHANNELS     = 68;
   localparam int BUCKETS      = 512;
   localparam int STORE_DEPTH  = CHIPS * CHANNELS * BUCKETS;
   localparam int SUM_DEPTH    = CHIPS * BUCKETS;
   localparam int QUIET_CYCLES = CHIPS * BUCKETS + 64;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 180;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  chip;
      logic [6:0]  chan;
      logic [8:0]  bucket;
      logic [11:0] sample;
   } fpn_cmd_type;

   typedef struct {
      logic [1:0] chip;
      logic [6:0] chan;
      logic [8:0] bucket;
   } site_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // chip[1:0], channel[8:2], bucket[17:9], sample_value[29:18]
   logic [1:0]  req_tuser = '0;  // kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;       // corrected_q4
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [11:0] csr_wdata = '0;

   // shadow state of the core
   logic [11:0] sample_shadow [STORE_DEPTH];
   logic [13:0] sum_shadow [SUM_DEPTH];
   logic [3:0]  seen_shadow [CHIPS];
   logic        fpn_en_shadow;
   logic [11:0] floor_shadow;

   // stimulus bookkeeping
   bit          written_map [STORE_DEPTH];
   site_type    stored_sites [$];
   fpn_cmd_type cmd_pending [$];
   fpn_cmd_type cmd_hold;
   logic [15:0] corrected_expect [$];

   int          accepted_count = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   logic        calm;

   assign calm = (accepted_count >= 500) && (accepted_count < 700);

   fixed_pattern_noise_subtract_core #(
      .CHIPS(CHIPS), .CHANNELS(CHANNELS), .BUCKETS(BUCKETS), .SAMPLE_BITS(12)
   ) DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [15:0] want,
                                  input logic [15:0] got);
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
      mismatches++;
   endtask

   task automatic clear_noise_shadow();
      foreach (sum_shadow[i]) sum_shadow[i] = '0;
      foreach (seen_shadow[i]) seen_shadow[i] = '0;
   endtask

   // shadow update for one accepted command; reads queue their corrected value
   task automatic predict_readout(input fpn_cmd_type c);
      int unsigned addr, saddr, n, mean_q4, raw_q4, floor_q4, res;
      bit          in_range;
      in_range = c.chan < CHANNELS;
      addr = (c.chip * CHANNELS + c.chan) * BUCKETS + c.bucket;
      saddr = c.chip * BUCKETS + c.bucket;
      case (c.kind)
         fpns_pkg::KIND_EVENT: clear_noise_shadow();
         fpns_pkg::KIND_LOAD: begin
            if (in_range) begin
               sample_shadow[addr] = c.sample;
               for (int i = 0; i < fpns_pkg::NOISE_COUNT; i++) begin
                  if (c.chan == fpns_pkg::NOISE_CHAN[i]) begin
                     sum_shadow[saddr] = sum_shadow[saddr] + 14'(c.sample);
                     seen_shadow[c.chip][i] = 1'b1;
                  end
               end
            end
         end
         fpns_pkg::KIND_READ: begin
            res = 0;
            if (in_range) begin
               raw_q4 = int'(sample_shadow[addr]) << 4;
               if (fpn_en_shadow) begin
                  n = 0;
                  for (int i = 0; i < fpns_pkg::NOISE_COUNT; i++) n += seen_shadow[c.chip][i];
                  mean_q4 = 0;
                  if (n != 0) mean_q4 = ((int'(sum_shadow[saddr]) << 4) + n / 2) / n;
                  floor_q4 = int'(floor_shadow) << 4;
                  if (raw_q4 < mean_q4 || raw_q4 - mean_q4 < floor_q4) res = floor_q4;
                  else res = raw_q4 - mean_q4;
               end else begin
                  res = raw_q4;
               end
               if (res > 16'hFFFF) res = 16'hFFFF;
            end
            corrected_expect.insert(corrected_expect.size(), 16'(res));
         end
         default: ;
      endcase
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_readout(cmd_hold);
            accepted_count <= accepted_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (cmd_pending.size() > 0 && (calm || $urandom_range(0, 99) >= 37)) begin
               cmd_hold = cmd_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {2'b00, cmd_hold.sample, cmd_hold.bucket, cmd_hold.chan,
                             cmd_hold.chip};
               req_tuser <= cmd_hold.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin : rsp_monitor
      logic [15:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (corrected_expect.size() == 0) begin
               report_mismatch("unexpected transfer, corrected_q4", '0, rsp_tdata);
            end else begin
               want = corrected_expect.pop_front();
               if (rsp_tdata !== want) report_mismatch("corrected_q4", want, rsp_tdata);
            end
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= 37);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic queue_cmd(input logic [1:0] kind, input logic [1:0] chip,
                            input logic [6:0] chan, input logic [8:0] bkt,
                            input logic [11:0] smp);
      fpn_cmd_type c;
      site_type    st;
      int unsigned addr;
      c = '{kind: kind, chip: chip, chan: chan, bucket: bkt, sample: smp};
      cmd_pending.insert(cmd_pending.size(), c);
      if (kind == fpns_pkg::KIND_LOAD && chan < CHANNELS) begin
         addr = (chip * CHANNELS + chan) * BUCKETS + bkt;
         if (!written_map[addr]) begin
            written_map[addr] = 1'b1;
            st = '{chip, chan, bkt};
            stored_sites.insert(stored_sites.size(), st);
         end
      end
   endtask

   task automatic write_csr(input logic idx, input logic [11:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == fpns_pkg::CSR_FPN_ENABLE) fpn_en_shadow = val[0];
      else floor_shadow = val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // drain: all commands taken, all results back, then let a sum sweep finish
   task automatic wait_quiet();
      while (cmd_pending.size() != 0 || req_tvalid || corrected_expect.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   function automatic logic [11:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 12'd0;
      if (r < 15) return 12'hFFF;
      return 12'($urandom_range(0, 4095));
   endfunction

   function automatic logic [8:0] pick_bucket();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 9'd0;
      if (r == 1) return 9'd511;
      return 9'($urandom_range(0, BUCKETS - 1));
   endfunction

   // one event: optional clear, loads on three buckets, reads, out-of-range, unknown kinds
   task automatic gen_event(input int n_items);
      logic [8:0] pool [3];
      site_type   recent [$];
      site_type   s;
      logic [1:0] chip;
      logic [6:0] chan;
      logic [8:0] bkt;
      int         r;
      if ($urandom_range(0, 9) != 0)
         queue_cmd(fpns_pkg::KIND_EVENT, 2'($urandom_range(0, 3)),
                   7'($urandom_range(0, 127)),
                   9'($urandom_range(0, 511)), 12'($urandom_range(0, 4095)));
      foreach (pool[i]) pool[i] = pick_bucket();
      repeat (n_items) begin
         r = $urandom_range(0, 99);
         chip = 2'($urandom_range(0, CHIPS - 1));
         bkt = pool[$urandom_range(0, 2)];
         if (r < 55) begin
            if (r < 35)
               chan = fpns_pkg::NOISE_CHAN[$urandom_range(0, fpns_pkg::NOISE_COUNT - 1)];
            else chan = 7'($urandom_range(0, CHANNELS - 1));
            queue_cmd(fpns_pkg::KIND_LOAD, chip, chan, bkt, pick_sample());
            s = '{chip, chan, bkt};
            recent.insert(recent.size(), s);
         end else if (r < 90) begin
            if (recent.size() > 0 && $urandom_range(0, 2) != 0)
               s = recent[$urandom_range(0, recent.size() - 1)];
            else
               s = stored_sites[$urandom_range(0, stored_sites.size() - 1)];
            queue_cmd(fpns_pkg::KIND_READ, s.chip, s.chan, s.bucket,
                      12'($urandom_range(0, 4095)));
         end else if (r < 95) begin
            chan = 7'($urandom_range(CHANNELS, 127));
            queue_cmd($urandom_range(0, 1) ? fpns_pkg::KIND_LOAD : fpns_pkg::KIND_READ,
                      chip, chan, 9'($urandom_range(0, 511)), pick_sample());
         end else begin
            queue_cmd(KIND_UNKNOWN, chip, 7'($urandom_range(0, 127)),
                      9'($urandom_range(0, 511)), 12'($urandom_range(0, 4095)));
         end
      end
   endtask

   initial begin : stimulus
      bit          phase_en [PHASES];
      logic [11:0] phase_floor [PHASES];
      int          target;
      phase_en = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      phase_floor = '{12'd0, 12'd4095, 12'd10, 12'($urandom_range(1, 400)), 12'd10, 12'd0};
      fpn_en_shadow = 1'b0;
      floor_shadow = fpns_pkg::FLOOR_RESET;
      clear_noise_shadow();
      foreach (sample_shadow[i]) sample_shadow[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_csr(fpns_pkg::CSR_FPN_ENABLE, 12'd1);
      write_csr(fpns_pkg::CSR_NOISE_FLOOR, 12'd0);

      // directed: extremes, out-of-range, mean of three and four channels,
      // partial noise channel, sum wrap, floor hit, unknown kind, new event
      queue_cmd(fpns_pkg::KIND_LOAD, 2'd0, 7'd0, 9'd0, 12'hFFF);
      queue_cmd(fpns_pkg::KIND_READ, 2'd0, 7'd0, 9'd0, 12'd0);
      queue_cmd(fpns_pkg::KIND_LOAD, 2'd0, 7'd127, 9'd511, 12'hABC);
      queue_cmd(fpns_pkg::KIND_READ, 2'd0, 7'd127, 9'd511, 12'd0);
      queue_cmd(fpns_pkg::KIND_READ, 2'd3, 7'd68, 9'd0, 12'hFFF);
      queue_cmd(fpns_pkg::KIND_LOAD, 2'd1, 7'd11, 9'd511, 12'd100);
      queue_cmd(fpns_pkg::KIND_LOAD, 2'd1, 7'd22, 9'd511, 12'd3);
      queue_cmd(fpns_pkg::KIND_LOAD, 2'd1, 7'd45, 9'd511, 12'd0);
      queue_cmd(fpns_pkg::KIND_LOAD, 2'd1, 7'd67, 9'd511, 12'd2000);
      queue_cmd(fpns_pkg::KIND_READ, 2'd1, 7'd67, 9'd511, 12'd0);
      queue_cmd(fpns_pkg::KIND_LOAD, 2'd1, 7'd56, 9'd0, 12'd50);
      queue_cmd(fpns_pkg::KIND_READ, 2'd1, 7'd67, 9'd511, 12'd0);
      queue_cmd(fpns_pkg::KIND_READ, 2'd1, 7'd11, 9'd511, 12'd0);
      repeat (5) queue_cmd(fpns_pkg::KIND_LOAD, 2'd2, 7'd11, 9'd5, 12'hFFF);
      queue_cmd(fpns_pkg::KIND_READ, 2'd2, 7'd11, 9'd5, 12'd0);
      queue_cmd(fpns_pkg::KIND_LOAD, 2'd2, 7'd0, 9'd5, 12'd1);
      queue_cmd(fpns_pkg::KIND_READ, 2'd2, 7'd0, 9'd5, 12'd0);
      queue_cmd(KIND_UNKNOWN, 2'd3, 7'd127, 9'd511, 12'hFFF);
      queue_cmd(fpns_pkg::KIND_EVENT, 2'd3, 7'd127, 9'd511, 12'hFFF);
      queue_cmd(fpns_pkg::KIND_READ, 2'd2, 7'd0, 9'd5, 12'd0);
      queue_cmd(fpns_pkg::KIND_READ, 2'd1, 7'd67, 9'd511, 12'd0);
      wait_quiet();

      for (int p = 0; p < PHASES; p++) begin
         write_csr(fpns_pkg::CSR_FPN_ENABLE, {11'd0, phase_en[p]});
         write_csr(fpns_pkg::CSR_NOISE_FLOOR, phase_floor[p]);
         target = cmd_pending.size() + PHASE_ITEMS;
         while (cmd_pending.size() < target) gen_event($urandom_range(25, 70));
         wait_quiet();
      end

      if (corrected_expect.size() != 0)
         report_mismatch("results never seen, count", 16'(corrected_expect.size()), '0);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/fpns_pkg.sv
rtl/fpns_ram.sv
rtl/fixed_pattern_noise_subtract_core.sv
dv/tb_top.sv
